@@ hw/rtl/set_assoc_cache_nru_lookup_assert.svh @@
// Assertion macros shared by the lookup block.
// Each takes a label, the clock, the reset, a condition, a consequence and a message.
`ifndef SET_ASSOC_CACHE_NRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_NRU_LOOKUP_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define SACN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence holds in the cycle after the condition.
`define SACN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sacn_pkg.sv @@
`timescale 1ns / 1ps

package sacn_pkg;

  // Built sizes of the cache.
  localparam int ADDR_BITS      = 32;
  localparam int MAX_INDEX_BITS = 10;
  localparam int MAX_WAYS       = 8;
  localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
  localparam int WAY_BITS       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NWAY_BITS      = $clog2(MAX_WAYS + 1);

  // Configuration register widths.
  localparam int AW_REG_BITS   = 6;
  localparam int OW_REG_BITS   = 4;
  localparam int IW_REG_BITS   = 4;
  localparam int NW_REG_BITS   = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 6;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ADDRESS_WIDTH = 2'd0,
    REG_OFFSET_WIDTH  = 2'd1,
    REG_INDEX_WIDTH   = 2'd2,
    REG_WAYS_IN_USE   = 2'd3
  } sacn_reg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } sacn_state_t;

  // Configuration after saturation, ready for the datapath.
  typedef struct packed {
    logic [ADDR_BITS-1:0]      addr_mask;
    logic [OW_REG_BITS-1:0]    offset;
    logic [MAX_INDEX_BITS-1:0] index_mask;
    logic [MAX_WAYS-1:0]       way_mask;
    logic [NWAY_BITS-1:0]      nways;
  } sacn_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic clr_write;
  } sacn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sacn_sts_t;

endpackage

@@ hw/rtl/sacn_if.sv @@
`timescale 1ns / 1ps

// Address channel: one address per beat.
interface sacn_req_if;
  logic                           valid;
  logic                           ready;
  logic [sacn_pkg::ADDR_BITS-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// Result channel: one lookup outcome per beat.
interface sacn_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                is_hit;
  logic [sacn_pkg::MAX_INDEX_BITS-1:0] set_number;
  logic [sacn_pkg::WAY_BITS-1:0]       way_number;
  modport source (output valid, output is_hit, output set_number, output way_number,
                  input ready);
  modport sink (input valid, input is_hit, input set_number, input way_number,
                output ready);
endinterface

// Configuration write channel.
interface sacn_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sacn_pkg::CFG_IDX_BITS-1:0]  index;
  logic [sacn_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/sacn_cfg.sv @@
`timescale 1ns / 1ps

module sacn_cfg (
  input  logic              clk,
  input  logic              rst,
  sacn_cfg_if.sink          cfg,
  output sacn_pkg::sacn_cfg_t cfg_out
);
  import sacn_pkg::*;

  logic [AW_REG_BITS-1:0]    address_width;
  logic [OW_REG_BITS-1:0]    offset_width;
  logic [IW_REG_BITS-1:0]    index_width;
  logic [NW_REG_BITS-1:0]    ways_in_use;
  logic [AW_REG_BITS-1:0]    aw_sat;
  logic [IW_REG_BITS-1:0]    iw_sat;
  logic [NW_REG_BITS-1:0]    nw_sat;
  logic [MAX_INDEX_BITS:0]   index_mask_wide;
  logic [MAX_WAYS:0]         way_mask_wide;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file, one register per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_width <= AW_REG_BITS'(ADDR_BITS);
      offset_width  <= '0;
      index_width   <= '0;
      ways_in_use   <= NW_REG_BITS'(MAX_WAYS);
    end else if (cfg.valid) begin
      unique case (sacn_reg_idx_t'(cfg.index))
        REG_ADDRESS_WIDTH: address_width <= cfg.data[AW_REG_BITS-1:0];
        REG_OFFSET_WIDTH:  offset_width  <= cfg.data[OW_REG_BITS-1:0];
        REG_INDEX_WIDTH:   index_width   <= cfg.data[IW_REG_BITS-1:0];
        REG_WAYS_IN_USE:   ways_in_use   <= cfg.data[NW_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the address width, index width and way count to the built sizes; a way count of zero becomes one.
  always_comb begin
    aw_sat = (address_width > AW_REG_BITS'(ADDR_BITS)) ? AW_REG_BITS'(ADDR_BITS)
                                                       : address_width;
    iw_sat = (index_width > IW_REG_BITS'(MAX_INDEX_BITS)) ? IW_REG_BITS'(MAX_INDEX_BITS)
                                                          : index_width;
    if (ways_in_use == '0) begin
      nw_sat = NW_REG_BITS'(1);
    end else if (ways_in_use > NW_REG_BITS'(MAX_WAYS)) begin
      nw_sat = NW_REG_BITS'(MAX_WAYS);
    end else begin
      nw_sat = ways_in_use;
    end
  end

  // Masks derived from the saturated settings.
  assign index_mask_wide = ((MAX_INDEX_BITS+1)'(1) << iw_sat) - (MAX_INDEX_BITS+1)'(1);
  assign way_mask_wide   = ((MAX_WAYS+1)'(1) << nw_sat) - (MAX_WAYS+1)'(1);

  always_comb begin
    cfg_out.addr_mask  = (aw_sat == AW_REG_BITS'(ADDR_BITS))
                       ? '1 : ((ADDR_BITS'(1) << aw_sat) - ADDR_BITS'(1));
    cfg_out.offset     = offset_width;
    cfg_out.index_mask = index_mask_wide[MAX_INDEX_BITS-1:0];
    cfg_out.way_mask   = way_mask_wide[MAX_WAYS-1:0];
    cfg_out.nways      = NWAY_BITS'(nw_sat);
  end

endmodule

@@ hw/rtl/sacn_ctrl.sv @@
`timescale 1ns / 1ps

module sacn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sacn_pkg::sacn_sts_t sts,
  output sacn_pkg::sacn_cmd_t cmd
);
  import sacn_pkg::*;
  `include "set_assoc_cache_nru_lookup_assert.svh"

  sacn_state_t state;
  sacn_state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_LOOKUP;
      S_LOOKUP: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.commit    = 1'b0;
    cmd.clr_write = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOOKUP: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

  `SACN_ASSERT_SAME(a_no_accept_in_clear, clk, rst, state == S_CLEAR, !in_ready,
                    "address taken during the clearing pass")
  `SACN_ASSERT_NEXT(a_accept_to_lookup, clk, rst, cmd.accept, state == S_LOOKUP,
                    "accepted beat did not move to lookup")
  `SACN_ASSERT_NEXT(a_lookup_holds, clk, rst, state == S_LOOKUP && !sts.out_free,
                    state == S_LOOKUP, "lookup left while the result slot was full")

endmodule

@@ hw/rtl/sacn_dpath.sv @@
`timescale 1ns / 1ps

module sacn_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  sacn_pkg::sacn_cfg_t          cfg,
  input  sacn_pkg::sacn_cmd_t          cmd,
  output sacn_pkg::sacn_sts_t          sts,
  input  logic [sacn_pkg::ADDR_BITS-1:0] address,
  sacn_rsp_if.source                   rsp
);
  import sacn_pkg::*;
  `include "set_assoc_cache_nru_lookup_assert.svh"

  // Tag rows and per-set valid/NRU bits.
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [NUM_SETS];
  logic [2*MAX_WAYS-1:0]              meta_mem [NUM_SETS];

  logic [ADDR_BITS-1:0]               tag_in;
  logic [MAX_INDEX_BITS-1:0]          set_in;
  logic [ADDR_BITS-1:0]               tag_q;
  logic [MAX_INDEX_BITS-1:0]          set_q;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row;
  logic [MAX_WAYS-1:0]                valid_row;
  logic [MAX_WAYS-1:0]                nru_row;
  logic [MAX_WAYS-1:0]                match;
  logic [MAX_WAYS-1:0]                nru_eff;
  logic [MAX_WAYS-1:0]                cand;
  logic                               hit;
  logic [WAY_BITS-1:0]                hit_way;
  logic [WAY_BITS-1:0]                victim;
  logic [WAY_BITS-1:0]                way_sel;
  logic [MAX_WAYS-1:0]                way_bit;
  logic [MAX_WAYS-1:0]                nru_new;
  logic [MAX_WAYS-1:0]                valid_new;
  logic [MAX_INDEX_BITS-1:0]          clr_cnt;

  // Tag and set of the incoming address.
  assign tag_in = (address & cfg.addr_mask) >> cfg.offset;
  assign set_in = tag_in[MAX_INDEX_BITS-1:0] & cfg.index_mask;

  // Capture the beat and read its set.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_q                <= tag_in;
      set_q                <= set_in;
      tag_row              <= tag_mem[set_in];
      {valid_row, nru_row} <= meta_mem[set_in];
    end
  end

  // Compare all ways in use; the lowest matching way wins.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      match[i] = valid_row[i] & cfg.way_mask[i] & (tag_row[i] == tag_q);
    end
    hit     = |match;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) hit_way = WAY_BITS'(i);
    end
  end

  // NRU victim: refill the bits of the ways in use when none is set.
  always_comb begin
    nru_eff = ((nru_row & cfg.way_mask) == '0) ? (nru_row | cfg.way_mask) : nru_row;
    cand    = nru_eff & cfg.way_mask;
    victim  = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (cand[i]) victim = WAY_BITS'(i);
    end
  end

  // Updated bits for the write back.
  always_comb begin
    way_sel   = hit ? hit_way : victim;
    way_bit   = MAX_WAYS'(1) << way_sel;
    nru_new   = (hit ? nru_row : nru_eff) & ~way_bit;
    valid_new = valid_row | way_bit;
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + MAX_INDEX_BITS'(1);
    end
  end

  // Valid/NRU write port: clearing pass or write back.
  always_ff @(posedge clk) begin
    if (cmd.clr_write) begin
      meta_mem[clr_cnt] <= {{MAX_WAYS{1'b0}}, {MAX_WAYS{1'b1}}};
    end else if (cmd.commit) begin
      meta_mem[set_q] <= {valid_new, nru_new};
    end
  end

  // Tag write on a miss.
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit) begin
      tag_mem[set_q][way_sel] <= tag_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.is_hit     <= hit;
      rsp.set_number <= set_q;
      rsp.way_number <= way_sel;
    end
  end

  // Status back to the controller.
  assign sts.clr_last = (clr_cnt == MAX_INDEX_BITS'(NUM_SETS - 1));
  assign sts.out_free = !rsp.valid || rsp.ready;

  `SACN_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, rsp.valid,
                    "write back did not present a result")
  `SACN_ASSERT_SAME(a_way_in_use, clk, rst, cmd.commit, NWAY_BITS'(way_sel) < cfg.nways,
                    "chosen way lies outside the ways in use")
  `SACN_ASSERT_SAME(a_clear_alone, clk, rst, cmd.clr_write, !cmd.commit && !cmd.accept,
                    "set access during the clearing pass")

endmodule

@@ hw/rtl/set_assoc_cache_nru_lookup.sv @@
`timescale 1ns / 1ps

// Channel  Role    Beat
// cfg      sink    register index and write data
// req      sink    one access address
// rsp      source  hit flag, set and way of that access
//
// An address is accepted and its set row is read; in the lookup state the
// tags are compared and tag, valid and NRU bits are written back once the
// result slot is free. The next address is taken after that write back.
// After reset a clearing pass runs over all 1024 sets, one set per cycle;
// no address is taken during it, configuration writes are.
// A result waits in an output register; while it is not taken the next
// address can be accepted and read, but its write back waits for the slot.
module set_assoc_cache_nru_lookup (
  input  logic       clk,
  input  logic       rst,
  sacn_cfg_if.sink   cfg,
  sacn_req_if.sink   req,
  sacn_rsp_if.source rsp
);
  import sacn_pkg::*;

  sacn_cfg_t cfg_val;
  sacn_cmd_t cmd;
  sacn_sts_t sts;

  // Configuration registers.
  sacn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_val)
  );

  // Sequencer.
  sacn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Set memories, compare and replacement.
  sacn_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_val),
    .cmd     (cmd),
    .sts     (sts),
    .address (req.address),
    .rsp     (rsp)
  );

endmodule

@@ tb/sv/sacn_lookup_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration, address and result channels of the lookup block,
// keeps its own copy of the cache and checks every result beat against it.
module sacn_lookup_checker (
  input  logic clk,
  input  logic rst,
  sacn_cfg_if  cfg,
  sacn_req_if  req,
  sacn_rsp_if  rsp,
  output int   mismatches,
  output int   pending,
  output int   hit_count,
  output int   miss_count
);
  import sacn_pkg::*;

  typedef struct packed {
    logic                      is_hit;
    logic [MAX_INDEX_BITS-1:0] set_number;
    logic [WAY_BITS-1:0]       way_number;
  } lookup_outcome_t;

  // Registers as last written.
  logic [AW_REG_BITS-1:0] addr_width_q;
  logic [OW_REG_BITS-1:0] offset_width_q;
  logic [IW_REG_BITS-1:0] index_width_q;
  logic [NW_REG_BITS-1:0] ways_q;

  // Cache contents: tags, valid flags and not-recently-used flags per set.
  logic [ADDR_BITS-1:0] tag_mem   [NUM_SETS][MAX_WAYS];
  logic [MAX_WAYS-1:0]  valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0]  nru_mem   [NUM_SETS];

  // Outcomes of accepted addresses whose result beat has not yet come.
  lookup_outcome_t outcome_q [$];

  int fail_total;
  int hits;
  int misses;

  // Looks one address up, updates the cache copy and returns the outcome.
  function automatic lookup_outcome_t lookup_and_update(logic [ADDR_BITS-1:0] address);
    int unsigned          aw;
    int unsigned          iw;
    int unsigned          nw;
    int unsigned          way;
    int unsigned          i;
    logic [63:0]          addr_mask;
    logic [31:0]          set_mask;
    logic [ADDR_BITS-1:0] tag;
    logic [MAX_INDEX_BITS-1:0] set_idx;
    logic [MAX_WAYS-1:0]  way_mask;
    bit                   found;
    bit                   victim_found;
    lookup_outcome_t      res;

    aw = (addr_width_q > ADDR_BITS) ? ADDR_BITS : addr_width_q;
    iw = (index_width_q > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_width_q;
    if (ways_q == 0) begin
      nw = 1;
    end else if (ways_q > MAX_WAYS) begin
      nw = MAX_WAYS;
    end else begin
      nw = ways_q;
    end

    // The tag keeps every meaningful bit above the block offset, index bits included.
    addr_mask = (64'd1 << aw) - 64'd1;
    tag       = (address & addr_mask[ADDR_BITS-1:0]) >> offset_width_q;
    set_mask  = (32'd1 << iw) - 32'd1;
    set_idx   = MAX_INDEX_BITS'(tag & set_mask);
    way_mask  = MAX_WAYS'((32'd1 << nw) - 32'd1);

    // The lowest valid way holding the tag wins.
    found = 1'b0;
    way   = 0;
    for (i = 0; i < nw; i++) begin
      if (!found && valid_mem[set_idx][i] && tag_mem[set_idx][i] == tag) begin
        found = 1'b1;
        way   = i;
      end
    end

    if (found) begin
      nru_mem[set_idx][way] = 1'b0;
    end else begin
      // With every way in use recently touched, all of them become candidates again.
      if ((nru_mem[set_idx] & way_mask) == '0) begin
        nru_mem[set_idx] = nru_mem[set_idx] | way_mask;
      end
      victim_found = 1'b0;
      for (i = 0; i < nw; i++) begin
        if (!victim_found && nru_mem[set_idx][i]) begin
          victim_found = 1'b1;
          way          = i;
        end
      end
      nru_mem[set_idx][way]   = 1'b0;
      valid_mem[set_idx][way] = 1'b1;
      tag_mem[set_idx][way]   = tag;
    end

    res.is_hit     = found;
    res.set_number = set_idx;
    res.way_number = WAY_BITS'(way);
    return res;
  endfunction

  // Register writes, result checks and predictions, in that order.
  always @(posedge clk) begin
    lookup_outcome_t want;
    lookup_outcome_t got;

    if (rst) begin
      addr_width_q   = AW_REG_BITS'(32);
      offset_width_q = '0;
      index_width_q  = '0;
      ways_q         = NW_REG_BITS'(8);
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_mem[s] = '0;
        nru_mem[s]   = '1;
      end
      outcome_q.delete();
      fail_total = 0;
      hits       = 0;
      misses     = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (sacn_reg_idx_t'(cfg.index))
          REG_ADDRESS_WIDTH: addr_width_q   = cfg.data[AW_REG_BITS-1:0];
          REG_OFFSET_WIDTH:  offset_width_q = cfg.data[OW_REG_BITS-1:0];
          REG_INDEX_WIDTH:   index_width_q  = cfg.data[IW_REG_BITS-1:0];
          REG_WAYS_IN_USE:   ways_q         = cfg.data[NW_REG_BITS-1:0];
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready) begin
        got.is_hit     = rsp.is_hit;
        got.set_number = rsp.set_number;
        got.way_number = rsp.way_number;
        if (outcome_q.size() == 0) begin
          $error("result beat with no lookup outstanding: is_hit %0d set %0d way %0d",
                 got.is_hit, got.set_number, got.way_number);
          fail_total++;
        end else begin
          want = outcome_q.pop_front();
          if (got.is_hit !== want.is_hit) begin
            $error("is_hit: expected %0d, got %0d", want.is_hit, got.is_hit);
            fail_total++;
          end
          if (got.set_number !== want.set_number) begin
            $error("set_number: expected %0d, got %0d", want.set_number, got.set_number);
            fail_total++;
          end
          if (got.way_number !== want.way_number) begin
            $error("way_number: expected %0d, got %0d", want.way_number, got.way_number);
            fail_total++;
          end
        end
      end

      if (req.valid && req.ready) begin
        want = lookup_and_update(req.address);
        if (want.is_hit) begin
          hits++;
        end else begin
          misses++;
        end
        outcome_q = {outcome_q, want};
      end
    end

    mismatches <= fail_total;
    pending    <= outcome_q.size();
    hit_count  <= hits;
    miss_count <= misses;
  end

endmodule

@@ tb/sv/set_assoc_cache_nru_lookup_tb.sv @@
`timescale 1ns / 1ps

// Drives addresses and register writes into the lookup block; the checker beside
// it predicts and compares, and this module gives the verdict.
module set_assoc_cache_nru_lookup_tb;
  import sacn_pkg::*;

  localparam int RECENT_DEPTH = 12;
  localparam int SEGMENT_LEN  = 40;

  logic clk = 1'b0;
  logic rst;

  sacn_cfg_if cfg_ch ();
  sacn_req_if req_ch ();
  sacn_rsp_if rsp_ch ();

  int mismatches;
  int pending;
  int hit_count;
  int miss_count;

  int send_idle_pct;
  int recv_idle_pct;
  int accesses;
  int settings;

  // Current address layout, used to aim random addresses at cached lines.
  int unsigned cur_aw;
  int unsigned cur_ow;
  logic [ADDR_BITS-1:0] recent_addr [RECENT_DEPTH];

  set_assoc_cache_nru_lookup i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sacn_lookup_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One register write beat; valid stays high for a following write.
  task automatic write_reg(input sacn_reg_idx_t idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Waits for the cache to drain, then writes all four registers.
  task automatic program_cache(input int unsigned aw, input int unsigned ow,
                               input int unsigned iw, input int unsigned nw);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_ADDRESS_WIDTH, aw);
    write_reg(REG_OFFSET_WIDTH, ow);
    write_reg(REG_INDEX_WIDTH, iw);
    write_reg(REG_WAYS_IN_USE, nw);
    cfg_ch.valid <= 1'b0;
    cur_aw = (aw > ADDR_BITS) ? ADDR_BITS : aw;
    cur_ow = ow;
    settings++;
  endtask

  // Picks a random setting, mostly realistic, sometimes out of range.
  task automatic random_setting();
    int unsigned aw;
    int unsigned ow;
    int unsigned iw;
    int unsigned nw;

    aw = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(32, 12);
    ow = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(4);
    iw = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(4);
    nw = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
    program_cache(aw, ow, iw, nw);
  endtask

  // Offers one address beat, idling first at the sender's rate.
  task automatic send_access(input logic [ADDR_BITS-1:0] address);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid   <= 1'b0;
      req_ch.address <= $urandom;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.address <= address;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    accesses++;
  endtask

  // Mostly revisits recent lines with fresh offset and masked-off bits, so that
  // hits, conflicts and evictions all occur; the rest is new lines and noise.
  task automatic random_segment(input int count);
    logic [ADDR_BITS-1:0] aw_mask;
    logic [ADDR_BITS-1:0] blk_mask;
    logic [ADDR_BITS-1:0] address;
    int unsigned          pick;
    int unsigned          slot;

    aw_mask  = (cur_aw >= ADDR_BITS) ? '1 : ((32'd1 << cur_aw) - 32'd1);
    blk_mask = (32'd1 << cur_ow) - 32'd1;
    repeat (count) begin
      pick = $urandom_range(99);
      slot = $urandom_range(RECENT_DEPTH - 1);
      if (pick < 55) begin
        address = recent_addr[slot] ^ ($urandom & ~(aw_mask & ~blk_mask));
      end else if (pick < 85) begin
        address           = $urandom;
        recent_addr[slot] = address;
      end else begin
        address = $urandom;
      end
      send_access(address);
    end
  endtask

  // The receiver stalls at its current rate, decided afresh every cycle.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_ADDRESS_WIDTH;
    cfg_ch.data    <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.address <= '0;
    send_idle_pct = 32;
    recv_idle_pct <= 78;
    accesses = 0;
    settings = 0;
    cur_aw   = ADDR_BITS;
    cur_ow   = 0;
    foreach (recent_addr[k]) recent_addr[k] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // One set of eight ways: extreme addresses, hits, then a ninth tag so that
    // every way has been used and the NRU flags are refilled.
    program_cache(32, 0, 0, 8);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    for (int k = 1; k <= 7; k++) send_access(32'(k));
    send_access(32'h0000_0000);

    // Zero address width with out-of-range offset, index and way count.
    program_cache(0, 15, 15, 0);
    send_access(32'hFFFF_FFFF);
    send_access(32'h1234_5678);

    // Address width above the built size, full index, way count above the built size.
    program_cache(63, 3, 10, 15);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0008);
    send_access(32'hFFFF_FFF8);

    // Offset no smaller than the address width: tag and index both zero.
    program_cache(4, 5, 2, 1);
    send_access(32'hABCD_EF01);
    send_access(32'h0000_0005);

    // Shrinking and regrowing the way count leaves one tag in two ways;
    // the lower one must hit.
    program_cache(32, 0, 0, 2);
    send_access(32'h0000_0A00);
    send_access(32'h0000_0B00);
    program_cache(32, 0, 0, 1);
    send_access(32'h0000_0A00);
    send_access(32'h0000_0B00);
    program_cache(32, 0, 0, 2);
    send_access(32'h0000_0B00);
    program_cache(32, 0, 0, 1);
    send_access(32'h0000_0A00);
    program_cache(32, 0, 0, 2);
    send_access(32'h0000_0A00);

    // Random part: three stall patterns, each over two fixed and two random settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct <= 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct <= 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ({phase[1:0], seg[1:0]})
          4'b0000: program_cache(63, 15, 15, 15);
          4'b0001: program_cache(32, 0, 2, 8);
          4'b0100: program_cache(1, 0, 10, 1);
          4'b0101: program_cache(0, 3, 4, 0);
          4'b1000: program_cache(32, 10, 10, 8);
          4'b1001: program_cache(20, 2, 3, 4);
          default: random_setting();
        endcase
        random_segment(SEGMENT_LEN);
      end
    end

    // Drain: every result must come back, then a few quiet cycles.
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d cache settings,",
             accesses, hit_count, miss_count, settings);
    $display("with sender and receiver stalls in turn and a final stretch without stalls.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guards against a hang anywhere in the run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d lookups still outstanding.", pending);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sacn_pkg.sv
hw/rtl/sacn_if.sv
hw/rtl/sacn_cfg.sv
hw/rtl/sacn_ctrl.sv
hw/rtl/sacn_dpath.sv
hw/rtl/set_assoc_cache_nru_lookup.sv
tb/sv/sacn_lookup_checker.sv
tb/sv/set_assoc_cache_nru_lookup_tb.sv
